// ===== design/keyed_slot_allocator_assert.svh =====
// Assertion macros for the keyed slot allocator checker.
// Needs clk_i and rst_ni visible in the scope that uses them.
`ifndef KEYED_SLOT_ALLOCATOR_ASSERT_SVH
`define KEYED_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define KSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_slot_allocator: assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define KSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_slot_allocator: assertion failed");

`endif

// ===== design/ksa_pkg.sv =====
// Shared types, constants and codes of the keyed slot allocator.
// No dependencies; used by every module file of the block and by its testbench.
`timescale 1ns / 1ps

package ksa_pkg;

  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned TAG_W     = 32;

  typedef enum logic [2:0] {
    ACT_TAKE_FIRST = 3'd0,
    ACT_TAKE_SLOT  = 3'd1,
    ACT_FREE_KEY   = 3'd2,
    ACT_LOOKUP     = 3'd3,
    ACT_READ       = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NO_FREE   = 3'd1,
    STS_RANGE     = 3'd2,
    STS_OCCUPIED  = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_DUPLICATE = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } slot_data_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    slot_data_t        wdata;
  } mem_req_t;

  // Clamp a requested slot count into 1 .. MAX_SLOTS.
  function automatic logic [CNT_W-1:0] clamp_slots(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) r = CNT_W'(1);
    else if (n > CNT_W'(MAX_SLOTS)) r = CNT_W'(MAX_SLOTS);
    return r;
  endfunction

endpackage

// ===== design/keyed_slot_allocator.sv =====
// Top level of the keyed slot allocator: sequencer plus slot memory.
// Depends on ksa_pkg, ksa_mem and ksa_ctrl.
//
// Use: raise start with action, plate_key, entry_time and slot_index; the
// request is taken at the edge where start is high and busy is low. busy
// stays high until the result is out. The result appears for exactly one
// cycle with done high; the receiver cannot hold it off.
// Requests that search for a key or a free slot walk every active
// slot through the memory's single read port, one slot a cycle, and then
// pass a drain state before the decision. Slot reads pass a read and a drain
// state; requests refused on range or occupancy go straight to the decision.
// The next request may be taken in the cycle done is high.
// Configuration: cfg_active_slots_i is written when cfg_valid and cfg_ready
// are both high (ready while idle); the write clears every slot at once and
// sets the free count to the clamped slot count (0 acts as 1, above 64 as 64).
// Reset: all slots free, 64 active slots, free count 64; no clearing pass.
`timescale 1ns / 1ps

module keyed_slot_allocator import ksa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        action_i,
  input  logic [KEY_W-1:0]  plate_key_i,
  input  logic [TAG_W-1:0]  entry_time_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_active_slots_i,
  output logic              done,
  output logic [2:0]        status_o,
  output logic [SLOT_W-1:0] result_slot_o,
  output logic              slot_occupied_o,
  output logic [KEY_W-1:0]  slot_key_o,
  output logic [TAG_W-1:0]  slot_time_o,
  output logic [CNT_W-1:0]  free_count_o
);

  mem_req_t   mem_req;
  slot_data_t mem_rdata;

  ksa_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .plate_key_i        (plate_key_i),
    .entry_time_i       (entry_time_i),
    .slot_index_i       (slot_index_i),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_slots_i (cfg_active_slots_i),
    .done               (done),
    .status_o           (status_o),
    .result_slot_o      (result_slot_o),
    .slot_occupied_o    (slot_occupied_o),
    .slot_key_o         (slot_key_o),
    .slot_time_o        (slot_time_o),
    .free_count_o       (free_count_o),
    .mem_req_o          (mem_req),
    .mem_rdata_i        (mem_rdata)
  );

  ksa_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== design/ksa_mem.sv =====
// Slot store: one synchronous single-port memory holding key and time tag per slot.
// Depends on ksa_pkg for the request and data types.
`timescale 1ns / 1ps

module ksa_mem import ksa_pkg::*; (
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output slot_data_t rdata_o
);

  slot_data_t mem [MAX_SLOTS];
  slot_data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ksa_ctrl.sv =====
// Sequencer of the keyed slot allocator: occupied marks, free count, slot walk,
// decision and write-back. Depends on ksa_pkg; drives the ksa_mem port.
`timescale 1ns / 1ps

module ksa_ctrl import ksa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  logic [KEY_W-1:0]     plate_key_i,
  input  logic [TAG_W-1:0]     entry_time_i,
  input  logic [SLOT_W-1:0]    slot_index_i,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CNT_W-1:0]     cfg_active_slots_i,
  output logic                 done,
  output logic [2:0]           status_o,
  output logic [SLOT_W-1:0]    result_slot_o,
  output logic                 slot_occupied_o,
  output logic [KEY_W-1:0]     slot_key_o,
  output logic [TAG_W-1:0]     slot_time_o,
  output logic [CNT_W-1:0]     free_count_o,
  output mem_req_t             mem_req_o,
  input  slot_data_t           mem_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_READ   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [MAX_SLOTS-1:0] occ_q, occ_d;
  logic [CNT_W-1:0]     active_q, active_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [2:0]           action_q;
  logic [KEY_W-1:0]     key_q;
  logic [TAG_W-1:0]     tag_q;
  logic [SLOT_W-1:0]    idx_q;

  logic [SLOT_W-1:0]    scan_q, scan_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0]    rd_addr_q;
  logic                 hit_q, hit_d;
  logic [SLOT_W-1:0]    hit_slot_q, hit_slot_d;
  logic [TAG_W-1:0]     hit_tag_q, hit_tag_d;
  logic                 free_hit_q, free_hit_d;
  logic [SLOT_W-1:0]    free_slot_q, free_slot_d;

  logic                 done_q;
  status_e              status_q, status_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 socc_q, socc_d;
  logic [KEY_W-1:0]     skey_q, skey_d;
  logic [TAG_W-1:0]     stag_q, stag_d;
  logic [CNT_W-1:0]     fcnt_q;

  logic                 accept;
  logic                 in_range;
  logic [CNT_W-1:0]     last_full;
  logic [SLOT_W-1:0]    last_slot;
  logic                 do_take;
  logic                 do_free;
  logic [SLOT_W-1:0]    take_slot;

  assign busy      = (state_q != S_IDLE);
  assign cfg_ready = (state_q == S_IDLE);
  assign accept    = start && (state_q == S_IDLE);
  assign in_range  = ({1'b0, idx_q} < active_q);
  assign last_full = active_q - CNT_W'(1);
  assign last_slot = last_full[SLOT_W-1:0];

  // Outcome of the request, evaluated in the decide cycle.
  always_comb begin
    status_d  = STS_OK;
    slot_d    = '0;
    socc_d    = 1'b0;
    skey_d    = '0;
    stag_d    = '0;
    do_take   = 1'b0;
    do_free   = 1'b0;
    take_slot = free_slot_q;
    unique case (action_q)
      ACT_TAKE_FIRST: begin
        if (hit_q) status_d = STS_DUPLICATE;
        else if (!free_hit_q) status_d = STS_NO_FREE;
        else begin
          do_take   = 1'b1;
          take_slot = free_slot_q;
        end
      end
      ACT_TAKE_SLOT: begin
        if (!in_range) status_d = STS_RANGE;
        else if (occ_q[idx_q]) status_d = STS_OCCUPIED;
        else if (hit_q) status_d = STS_DUPLICATE;
        else begin
          do_take   = 1'b1;
          take_slot = idx_q;
        end
      end
      ACT_FREE_KEY: begin
        if (!hit_q) status_d = STS_NOT_FOUND;
        else begin
          do_free = 1'b1;
          slot_d  = hit_slot_q;
        end
      end
      ACT_LOOKUP: begin
        if (!hit_q) status_d = STS_NOT_FOUND;
        else begin
          slot_d = hit_slot_q;
          socc_d = 1'b1;
          skey_d = key_q;
          stag_d = hit_tag_q;
        end
      end
      default: begin
        if (!in_range) status_d = STS_RANGE;
        else begin
          slot_d = idx_q;
          socc_d = occ_q[idx_q];
          if (occ_q[idx_q]) begin
            skey_d = mem_rdata_i.key;
            stag_d = mem_rdata_i.tag;
          end
        end
      end
    endcase
    if (do_take) begin
      slot_d = take_slot;
      socc_d = 1'b1;
      skey_d = key_q;
      stag_d = tag_q;
    end
  end

  // Sequencer, slot walk and table update.
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_tag_d   = hit_tag_q;
    free_hit_d  = free_hit_q;
    free_slot_d = free_slot_q;
    mem_req_o   = '{we: 1'b0, re: 1'b0, addr: scan_q, wdata: '{key: key_q, tag: tag_q}};

    // Compare the slot read last cycle.
    if (rd_vld_q) begin
      if (occ_q[rd_addr_q] && (mem_rdata_i.key == key_q) && !hit_q) begin
        hit_d      = 1'b1;
        hit_slot_d = rd_addr_q;
        hit_tag_d  = mem_rdata_i.tag;
      end
      if (!occ_q[rd_addr_q] && !free_hit_q) begin
        free_hit_d  = 1'b1;
        free_slot_d = rd_addr_q;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid) begin
          active_d = clamp_slots(cfg_active_slots_i);
          cnt_d    = clamp_slots(cfg_active_slots_i);
          occ_d    = '0;
        end
        if (accept) begin
          scan_d     = '0;
          hit_d      = 1'b0;
          free_hit_d = 1'b0;
          priority case (action_i)
            ACT_TAKE_FIRST, ACT_FREE_KEY, ACT_LOOKUP: state_d = S_SCAN;
            ACT_TAKE_SLOT: begin
              if (({1'b0, slot_index_i} < active_q) && !occ_q[slot_index_i]) begin
                state_d = S_SCAN;
              end else begin
                state_d = S_DECIDE;
              end
            end
            default: begin
              if ({1'b0, slot_index_i} < active_q) state_d = S_READ;
              else state_d = S_DECIDE;
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_req_o.re = 1'b1;
        rd_vld_d     = 1'b1;
        if (scan_q == last_slot) state_d = S_DRAIN;
        else scan_d = scan_q + SLOT_W'(1);
      end
      S_READ: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = idx_q;
        state_d        = S_DRAIN;
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (do_take) begin
          mem_req_o.we     = 1'b1;
          mem_req_o.addr   = take_slot;
          occ_d[take_slot] = 1'b1;
          cnt_d            = cnt_q - CNT_W'(1);
        end
        if (do_free) begin
          occ_d[hit_slot_q] = 1'b0;
          cnt_d             = cnt_q + CNT_W'(1);
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      active_q <= CNT_W'(MAX_SLOTS);
      cnt_q    <= CNT_W'(MAX_SLOTS);
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      done_q   <= (state_q == S_DECIDE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      key_q    <= plate_key_i;
      tag_q    <= entry_time_i;
      idx_q    <= slot_index_i;
    end
    scan_q      <= scan_d;
    rd_addr_q   <= scan_q;
    hit_q       <= hit_d;
    hit_slot_q  <= hit_slot_d;
    hit_tag_q   <= hit_tag_d;
    free_hit_q  <= free_hit_d;
    free_slot_q <= free_slot_d;
    if (state_q == S_DECIDE) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      socc_q   <= socc_d;
      skey_q   <= skey_d;
      stag_q   <= stag_d;
      fcnt_q   <= cnt_d;
    end
  end

  assign done            = done_q;
  assign status_o        = status_q;
  assign result_slot_o   = slot_q;
  assign slot_occupied_o = socc_q;
  assign slot_key_o      = skey_q;
  assign slot_time_o     = stag_q;
  assign free_count_o    = fcnt_q;

endmodule

// ===== design/ksa_chk.sv =====
// Port-level checker for the keyed slot allocator, bound to the top level.
// Depends on ksa_pkg and keyed_slot_allocator_assert.svh.
`timescale 1ns / 1ps
`include "keyed_slot_allocator_assert.svh"

module ksa_chk import ksa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [2:0]        action_i,
  input logic [KEY_W-1:0]  plate_key_i,
  input logic [TAG_W-1:0]  entry_time_i,
  input logic [SLOT_W-1:0] slot_index_i,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [CNT_W-1:0]  cfg_active_slots_i,
  input logic              done,
  input logic [2:0]        status_o,
  input logic [SLOT_W-1:0] result_slot_o,
  input logic              slot_occupied_o,
  input logic [KEY_W-1:0]  slot_key_o,
  input logic [TAG_W-1:0]  slot_time_o,
  input logic [CNT_W-1:0]  free_count_o
);

  // A taken request holds the block busy.
  `KSA_ASSERT_NEXT(a_take_busy, start && !busy, busy)

  // One result per request: never two strobes in a row.
  `KSA_ASSERT_NEXT(a_done_single, done, !done)

  // A refused request reports an empty slot.
  `KSA_ASSERT_IMPL(a_err_zero, done && (status_o != STS_OK), (result_slot_o == '0) && !slot_occupied_o && (slot_key_o == '0) && (slot_time_o == '0))

  // A free slot reads as zero, and the free count stays within the table.
  `KSA_ASSERT_IMPL(a_free_zero, done && !slot_occupied_o, (slot_key_o == '0) && (slot_time_o == '0) && (free_count_o <= CNT_W'(MAX_SLOTS)))

endmodule

bind keyed_slot_allocator ksa_chk u_ksa_chk (.*);

// ===== test/tb_keyed_slot_allocator.sv =====
// Self-checking testbench for keyed_slot_allocator: directed and random requests
// checked against a cycle-free slot table predictor, under several slot counts.
// Depends on ksa_pkg and the keyed_slot_allocator RTL.
`timescale 1ns / 1ps

module tb_keyed_slot_allocator;
  import ksa_pkg::*;

  localparam int          CLK_HALF_NS    = 6;
  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 80;
  localparam longint      TIMEOUT_CYCLES = 600000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          KEY_POOL_MAX   = 40;
  // Codes 5 to 7 are not decoded and behave as a slot read.
  localparam logic [2:0]  ACT_UNUSED_MAX = 3'b111;

  typedef enum logic [1:0] {
    ITEM_REQ,
    ITEM_CFG,
    ITEM_DRAIN
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [2:0]        action;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] idx;
    logic [CNT_W-1:0]  slots;
    logic [6:0]        gap_pct;
  } stim_item_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              occ;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  free;
  } alloc_result_t;

  logic              clk_i              = 1'b0;
  logic              rst_ni             = 1'b0;
  logic              start              = 1'b0;
  logic              busy;
  logic [2:0]        action_i           = '0;
  logic [KEY_W-1:0]  plate_key_i        = '0;
  logic [TAG_W-1:0]  entry_time_i       = '0;
  logic [SLOT_W-1:0] slot_index_i       = '0;
  logic              cfg_valid          = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_active_slots_i = '0;
  logic              done;
  logic [2:0]        status_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic              slot_occupied_o;
  logic [KEY_W-1:0]  slot_key_o;
  logic [TAG_W-1:0]  slot_time_o;
  logic [CNT_W-1:0]  free_count_o;

  keyed_slot_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .plate_key_i       (plate_key_i),
    .entry_time_i      (entry_time_i),
    .slot_index_i      (slot_index_i),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_active_slots_i(cfg_active_slots_i),
    .done              (done),
    .status_o          (status_o),
    .result_slot_o     (result_slot_o),
    .slot_occupied_o   (slot_occupied_o),
    .slot_key_o        (slot_key_o),
    .slot_time_o       (slot_time_o),
    .free_count_o      (free_count_o)
  );

  stim_item_t       request_q[$];
  alloc_result_t    predicted_results[$];
  logic [KEY_W-1:0] key_pool[$];
  int               issued_cnt  = 0;
  int               retired_cnt = 0;
  int               err_cnt     = 0;

  // Predicted slot table
  logic             occ_mark [MAX_SLOTS];
  logic [KEY_W-1:0] held_key [MAX_SLOTS];
  logic [TAG_W-1:0] held_tag [MAX_SLOTS];
  int               live_slots;
  int               free_slots;

  function automatic void clear_slots(logic [CNT_W-1:0] req);
    int n;
    n = req;
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      occ_mark[i] = 1'b0;
      held_key[i] = '0;
      held_tag[i] = '0;
    end
    live_slots = n;
    free_slots = n;
  endfunction

  function automatic int slot_of_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < live_slots; i++) begin
      if (occ_mark[i] && held_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void claim_slot(int s, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    occ_mark[s] = 1'b1;
    held_key[s] = k;
    held_tag[s] = t;
    free_slots--;
  endfunction

  function automatic alloc_result_t predict_outcome(logic [2:0] act, logic [KEY_W-1:0] k,
                                                    logic [TAG_W-1:0] t,
                                                    logic [SLOT_W-1:0] idx);
    alloc_result_t res;
    status_e       st;
    int            s;
    int            hit;
    st  = STS_OK;
    s   = 0;
    hit = slot_of_key(k);
    case (act)
      ACT_TAKE_FIRST: begin
        if (hit >= 0) begin
          st = STS_DUPLICATE;
        end else begin
          s = -1;
          for (int i = live_slots - 1; i >= 0; i--) begin
            if (!occ_mark[i]) s = i;
          end
          if (s < 0) begin
            st = STS_NO_FREE;
            s  = 0;
          end else begin
            claim_slot(s, k, t);
          end
        end
      end
      ACT_TAKE_SLOT: begin
        // Range first, then occupancy, then duplicate key
        if (idx >= live_slots) st = STS_RANGE;
        else if (occ_mark[idx]) st = STS_OCCUPIED;
        else if (hit >= 0) st = STS_DUPLICATE;
        else begin
          s = idx;
          claim_slot(s, k, t);
        end
      end
      ACT_FREE_KEY: begin
        if (hit < 0) begin
          st = STS_NOT_FOUND;
        end else begin
          s           = hit;
          occ_mark[s] = 1'b0;
          held_key[s] = '0;
          held_tag[s] = '0;
          free_slots++;
        end
      end
      ACT_LOOKUP: begin
        if (hit < 0) st = STS_NOT_FOUND;
        else s = hit;
      end
      default: begin
        if (idx >= live_slots) st = STS_RANGE;
        else s = idx;
      end
    endcase
    res.status = st;
    res.free   = CNT_W'(free_slots);
    if (st == STS_OK) begin
      res.slot = SLOT_W'(s);
      res.occ  = occ_mark[s];
      res.key  = held_key[s];
      res.tag  = held_tag[s];
    end else begin
      res.slot = '0;
      res.occ  = 1'b0;
      res.key  = '0;
      res.tag  = '0;
    end
    return res;
  endfunction

  task automatic note_failure(string what, logic [63:0] want, logic [63:0] got);
    if (err_cnt < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
    err_cnt++;
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) note_failure(what, want, got);
  endtask

  // Stimulus building

  task automatic push_req(logic [2:0] act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                          logic [SLOT_W-1:0] idx, int gap);
    stim_item_t it;
    it         = '0;
    it.kind    = ITEM_REQ;
    it.action  = act;
    it.key     = k;
    it.tag     = t;
    it.idx     = idx;
    it.gap_pct = 7'(gap);
    request_q  = {request_q, it};
  endtask

  task automatic push_cfg(logic [CNT_W-1:0] n);
    stim_item_t it;
    it        = '0;
    it.kind   = ITEM_CFG;
    it.slots  = n;
    request_q = {request_q, it};
  endtask

  task automatic push_drain();
    stim_item_t it;
    it        = '0;
    it.kind   = ITEM_DRAIN;
    request_q = {request_q, it};
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int fresh_pct);
    logic [KEY_W-1:0] k;
    if (key_pool.size() == 0 || $urandom_range(99) < fresh_pct) begin
      case ($urandom_range(15))
        0:       k = '0;
        1:       k = '1;
        default: k = {$urandom, $urandom};
      endcase
      if (key_pool.size() < KEY_POOL_MAX) key_pool = {key_pool, k};
      else key_pool[$urandom_range(KEY_POOL_MAX - 1)] = k;
    end else begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end
    return k;
  endfunction

  task automatic push_random_req(int gap, int take_w, int fresh_pct, int eff_slots);
    logic [2:0]        act;
    logic [TAG_W-1:0]  t;
    logic [SLOT_W-1:0] idx;
    int                r;
    int                hi;
    r = $urandom_range(99);
    if (r < take_w) begin
      act = (r % 2) ? ACT_TAKE_SLOT : ACT_TAKE_FIRST;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: act = ACT_FREE_KEY;
        4, 5, 6:    act = ACT_LOOKUP;
        7, 8:       act = ACT_READ;
        default:    act = 3'($urandom_range(ACT_UNUSED_MAX, ACT_READ + 1));
      endcase
    end
    case ($urandom_range(9))
      0:       t = '0;
      1:       t = '1;
      default: t = $urandom;
    endcase
    // Mostly stay near the active range, one step over it included
    hi = (eff_slots > MAX_SLOTS - 1) ? MAX_SLOTS - 1 : eff_slots;
    if ($urandom_range(3) == 0) idx = SLOT_W'($urandom_range(MAX_SLOTS - 1));
    else idx = SLOT_W'($urandom_range(hi));
    push_req(act, pick_key(fresh_pct), t, idx, gap);
  endtask

  // Clock, reset, watchdog

  initial begin : clock_gen
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin : reset_gen
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Driver: issue requests and register writes from request_q

  always @(posedge clk_i) begin : driver
    stim_item_t head;
    logic       next_start;
    logic       next_cfg;
    logic       accepted;
    if (!rst_ni) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      clear_slots(CNT_W'(MAX_SLOTS));
    end else begin
      next_start = start;
      next_cfg   = cfg_valid;
      accepted   = start && !busy;
      if (accepted) begin
        predicted_results = {predicted_results,
                             predict_outcome(action_i, plate_key_i, entry_time_i,
                                             slot_index_i)};
        issued_cnt <= issued_cnt + 1;
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        clear_slots(cfg_active_slots_i);
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && request_q.size() != 0) begin
        head = request_q[0];
        case (head.kind)
          ITEM_REQ: begin
            if ($urandom_range(99) >= head.gap_pct) begin
              head         = request_q.pop_front();
              next_start   = 1'b1;
              action_i     <= head.action;
              plate_key_i  <= head.key;
              entry_time_i <= head.tag;
              slot_index_i <= head.idx;
            end
          end
          ITEM_CFG: begin
            // Write only once every request has delivered its result
            if (!accepted && !busy && issued_cnt == retired_cnt) begin
              head               = request_q.pop_front();
              next_cfg           = 1'b1;
              cfg_active_slots_i <= head.slots;
            end
          end
          default: begin
            if (!accepted && issued_cnt == retired_cnt) head = request_q.pop_front();
          end
        endcase
      end
      start     <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // Monitor: compare every result with the oldest prediction

  always @(posedge clk_i) begin : monitor
    alloc_result_t want;
    if (rst_ni && done) begin
      if (predicted_results.size() == 0) begin
        note_failure("unexpected result", '0, {61'd0, status_o});
      end else begin
        want = predicted_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("result_slot", want.slot, result_slot_o);
        check_field("slot_occupied", want.occ, slot_occupied_o);
        check_field("slot_key", want.key, slot_key_o);
        check_field("slot_time", want.tag, slot_time_o);
        check_field("free_count", want.free, free_count_o);
        retired_cnt <= retired_cnt + 1;
      end
    end
  end

  // Stimulus and end of run

  initial begin : stimulus
    int         phase_slots[9];
    int         phase_gap[9];
    int         phase_len[9];
    int         phase_take[9];
    int         phase_fresh[9];
    int         eff;
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;
    phase_slots = '{64, 64, 1, 0, 5, 127, 33, 63, 64};
    phase_gap   = '{0, 61, 35, 0, 61, 35, 0, 35, 61};
    phase_len   = '{150, 150, 100, 60, 120, 150, 120, 100, 100};
    phase_take  = '{80, 45, 45, 45, 45, 60, 45, 50, 40};
    phase_fresh = '{90, 40, 40, 50, 40, 60, 40, 50, 30};
    ka = {$urandom, $urandom};
    kb = {$urandom, $urandom};

    // Empty table at reset size: free slots read as zero, key zero is not found until it is taken
    push_req(ACT_READ, '0, '0, '0, 0);
    push_req(ACT_READ, '0, '0, SLOT_W'(MAX_SLOTS - 1), 0);
    push_req(ACT_LOOKUP, '0, '0, '0, 0);
    push_req(ACT_FREE_KEY, '0, '0, '0, 0);
    push_req(ACT_TAKE_FIRST, '1, '1, '0, 0);
    push_req(ACT_TAKE_FIRST, '1, '0, '0, 0);
    push_req(ACT_TAKE_SLOT, '0, '0, SLOT_W'(MAX_SLOTS - 1), 0);
    push_req(ACT_TAKE_SLOT, ka, '1, SLOT_W'(MAX_SLOTS - 1), 0);
    push_req(ACT_TAKE_SLOT, '1, '1, SLOT_W'(5), 0);
    push_req(ACT_LOOKUP, '1, '0, '0, 0);
    push_req(ACT_LOOKUP, '0, '0, '0, 0);
    push_req(ACT_READ, '0, '0, SLOT_W'(MAX_SLOTS - 1), 0);
    for (int a = ACT_READ + 1; a <= ACT_UNUSED_MAX; a++) begin
      push_req(3'(a), '1, '1, SLOT_W'(a == ACT_UNUSED_MAX ? MAX_SLOTS - 1 : a - 5), 0);
    end
    push_req(ACT_FREE_KEY, '1, '0, '0, 0);
    push_req(ACT_TAKE_FIRST, ka, 32'h0000_0001, '0, 0);
    push_req(ACT_FREE_KEY, '0, '0, '0, 0);

    // Two slots: range refusals, exhaustion, occupied slot
    push_cfg(CNT_W'(2));
    push_req(ACT_TAKE_SLOT, kb, '1, SLOT_W'(2), 0);
    push_req(ACT_READ, '0, '0, SLOT_W'(MAX_SLOTS - 1), 0);
    push_req(ACT_UNUSED_MAX, '0, '0, SLOT_W'(5), 0);
    push_req(ACT_TAKE_FIRST, ka, '1, '0, 0);
    push_req(ACT_TAKE_FIRST, kb, '0, '0, 0);
    push_req(ACT_TAKE_FIRST, '0, '1, '0, 0);
    push_req(ACT_TAKE_SLOT, '0, '1, SLOT_W'(1), 0);

    for (int p = 0; p < 9; p++) begin
      eff = phase_slots[p];
      if (eff < 1) eff = 1;
      if (eff > MAX_SLOTS) eff = MAX_SLOTS;
      push_cfg(CNT_W'(phase_slots[p]));
      for (int i = 0; i < phase_len[p]; i++) begin
        // Hold off mid-phase until the block has gone quiet
        if (i == phase_len[p] / 2) push_drain();
        push_random_req(phase_gap[p], phase_take[p], phase_fresh[p], eff);
      end
    end

    @(posedge rst_ni);
    while (request_q.size() != 0 || start || cfg_valid || issued_cnt != retired_cnt) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0) begin
      note_failure("undelivered results", predicted_results.size(), '0);
    end
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ksa_pkg.sv
design/ksa_mem.sv
design/ksa_ctrl.sv
design/keyed_slot_allocator.sv
design/ksa_chk.sv
test/tb_keyed_slot_allocator.sv
